### design/mfmt_pkg.sv
package mfmt_pkg;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 96;

	localparam int ID_W      = 11;
	localparam int COUNT_W   = 13;
	localparam int RATIO_W   = 16;
	localparam int ANGLE_W   = 48;
	localparam int SPEED_W   = 16;
	localparam int CURRENT_W = 19;
	localparam int TEMP_W    = 8;
	localparam int CFG_W     = 16;

	// divider geometry: dividend = |d| * 360 * 2^24 + den / 2, den = 8191 * ratio
	localparam int QUOT_W     = 32;
	localparam int DIVISOR_W  = 29;
	localparam int DIVIDEND_W = 46;
	localparam int STEP_W     = 5;
	localparam int MAG_W      = 12;
	localparam int MAG360_W   = 21;

	localparam logic [ID_W-1:0]    EXPECTED_ID_RST = 11'd513;
	localparam logic [RATIO_W-1:0] GEAR_RATIO_RST  = 16'd4916;

	localparam logic [COUNT_W-1:0]       COUNT_FULL = 13'd8191;
	localparam logic signed [13:0]       HALF_POS   = 14'sd4096;
	localparam logic signed [13:0]       HALF_NEG   = -14'sd4096;
	localparam logic signed [13:0]       FULL_S     = 14'sd8191;
	localparam logic signed [19:0]       CUR_MAX    = 20'sd163835;
	localparam logic signed [19:0]       CUR_MIN    = -20'sd163840;
	localparam logic signed [ANGLE_W-1:0] ACC_MAX   = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [ANGLE_W-1:0] ACC_MIN   = 48'sh8000_0000_0000;

	typedef enum logic {
		CFG_EXPECTED_ID = 1'b0,
		CFG_GEAR_RATIO  = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_LOAD,
		ST_DIV,
		ST_ACCUM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                 id_match;
		logic [COUNT_W-1:0]   count;
		logic [SPEED_W-1:0]   speed;
		logic [CURRENT_W-1:0] current;
		logic [TEMP_W-1:0]    temp;
	} fb_decode_t;

endpackage

### design/mfmt_decode.sv
module mfmt_decode (
	input  logic [mfmt_pkg::IN_DATA_W-1:0] tdata,
	input  logic [mfmt_pkg::ID_W-1:0]      expected_id,
	output mfmt_pkg::fb_decode_t           dec
);

	logic [15:0]        angle_raw;
	logic signed [15:0] cur_raw;
	logic signed [19:0] cur_ext;
	logic signed [19:0] cur_x10;

	always_comb begin
		angle_raw = {tdata[18:11], tdata[26:19]};
		cur_raw   = signed'({tdata[50:43], tdata[58:51]});
		cur_ext   = 20'(cur_raw);
		// times ten as 8x + 2x
		cur_x10   = (cur_ext <<< 3) + (cur_ext <<< 1);

		dec.id_match = (tdata[10:0] == expected_id);
		dec.count    = (angle_raw > {3'b000, mfmt_pkg::COUNT_FULL}) ?
			mfmt_pkg::COUNT_FULL : angle_raw[12:0];
		dec.speed    = {tdata[34:27], tdata[42:35]};
		if (cur_x10 > mfmt_pkg::CUR_MAX) begin
			dec.current = mfmt_pkg::CUR_MAX[18:0];
		end else if (cur_x10 < mfmt_pkg::CUR_MIN) begin
			dec.current = mfmt_pkg::CUR_MIN[18:0];
		end else begin
			dec.current = cur_x10[18:0];
		end
		dec.temp = tdata[66:59];
	end

endmodule

### design/mfmt_div.sv
module mfmt_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [mfmt_pkg::DIVIDEND_W-1:0]   dividend,
	input  logic [mfmt_pkg::DIVISOR_W-1:0]    divisor,
	output logic                              done,
	output logic [mfmt_pkg::QUOT_W-1:0]       quotient
);

	localparam logic [mfmt_pkg::STEP_W-1:0] STEP_LAST = mfmt_pkg::STEP_W'(mfmt_pkg::QUOT_W - 1);

	logic                               busy_q;
	logic [mfmt_pkg::STEP_W-1:0]        cnt_q;
	logic [mfmt_pkg::DIVISOR_W-1:0]     rem_q;
	logic [mfmt_pkg::QUOT_W-1:0]        quo_q;
	logic [mfmt_pkg::DIVISOR_W+1:0]     trial;

	// one restoring step: shift in the next dividend bit, try the subtract
	assign trial    = {1'b0, rem_q, quo_q[mfmt_pkg::QUOT_W-1]} - {2'b00, divisor};
	assign done     = busy_q && (cnt_q == STEP_LAST);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// upper dividend bits are below the divisor since the quotient fits QUOT_W
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {15'd0, dividend[mfmt_pkg::DIVIDEND_W-1:mfmt_pkg::QUOT_W]};
			quo_q <= dividend[mfmt_pkg::QUOT_W-1:0];
		end else if (busy_q) begin
			if (trial[mfmt_pkg::DIVISOR_W+1]) begin
				rem_q <= {rem_q[mfmt_pkg::DIVISOR_W-2:0], quo_q[mfmt_pkg::QUOT_W-1]};
			end else begin
				rem_q <= trial[mfmt_pkg::DIVISOR_W-1:0];
			end
			quo_q <= {quo_q[mfmt_pkg::QUOT_W-2:0], ~trial[mfmt_pkg::DIVISOR_W+1]};
		end
	end

endmodule

### design/motor_feedback_multiturn_tracker.sv
// Channel   Dir  Handshake              Content
// s_axis    in   tvalid/tready          one received feedback frame word
// m_axis    out  tvalid/tready          decoded feedback and multi-turn angle word
// cfg       in   cfg_we (no wait)       expected_id (index 0), gear_ratio (index 1)
//
// A frame with a foreign identifier is dropped in its accept cycle.
// The first matching frame after reset goes straight to the result state; every later
// matching frame holds s_axis_tready low through the prepare, load, divide, accumulate
// and result states, the divide being bit-serial by 8191 * gear_ratio, which sets the rate.
// A finished word waits in the output register; a new frame is taken meanwhile,
// and its result waits in the sequencer until the output register frees up.
// arst_n clears the sequencer, the angle state, the configuration registers and the output valid flag.
module motor_feedback_multiturn_tracker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// frame_id[10:0], angle_high[18:11], angle_low[26:19], speed_high[34:27],
	// speed_low[42:35], current_high[50:43], current_low[58:51], temp_byte[66:59]
	input  logic [mfmt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// output_angle[47:0], speed_rpm[63:48], current_amps[82:64], temperature[90:83]
	output logic [mfmt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// first_frame[0]
	output logic [0:0]                        m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [mfmt_pkg::CFG_W-1:0]        cfg_wdata
);

	mfmt_pkg::state_t state_q, state_d;

	logic [mfmt_pkg::ID_W-1:0]     expected_id_q;
	logic [mfmt_pkg::RATIO_W-1:0]  gear_ratio_q;

	logic                          awaiting_q;
	logic [mfmt_pkg::COUNT_W-1:0]  prev_count_q;
	logic [mfmt_pkg::ANGLE_W-1:0]  acc_q;

	mfmt_pkg::fb_decode_t          dec;
	mfmt_pkg::fb_decode_t          dec_q;
	logic                          first_q;

	logic                          neg_q;
	logic [mfmt_pkg::MAG360_W-1:0] mag360_q;
	logic [mfmt_pkg::DIVISOR_W-1:0] den_q;

	logic                          out_valid_q;
	logic [mfmt_pkg::ANGLE_W-1:0]  out_angle_q;
	logic [mfmt_pkg::SPEED_W-1:0]  out_speed_q;
	logic [mfmt_pkg::CURRENT_W-1:0] out_current_q;
	logic [mfmt_pkg::TEMP_W-1:0]   out_temp_q;
	logic                          out_first_q;

	logic                          in_acc;
	logic                          out_load;
	logic                          div_start;
	logic                          div_done;
	logic [mfmt_pkg::QUOT_W-1:0]   quotient;
	logic [mfmt_pkg::DIVIDEND_W-1:0] dividend;

	logic signed [13:0]            d_raw;
	logic signed [13:0]            d_wrap;
	logic [13:0]                   d_neg;
	logic [mfmt_pkg::MAG_W-1:0]    mag;
	logic [mfmt_pkg::MAG360_W-1:0] mag_ext;
	logic [mfmt_pkg::MAG360_W-1:0] mag360;
	logic [mfmt_pkg::RATIO_W-1:0]  ratio_eff;
	logic [mfmt_pkg::DIVISOR_W-1:0] den;
	logic signed [32:0]            q_s;
	logic signed [48:0]            sum;

	mfmt_decode u_decode (
		.tdata       (s_axis_tdata),
		.expected_id (expected_id_q),
		.dec         (dec)
	);

	mfmt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q <= mfmt_pkg::EXPECTED_ID_RST;
			gear_ratio_q  <= mfmt_pkg::GEAR_RATIO_RST;
		end else if (cfg_we) begin
			unique case (mfmt_pkg::cfg_index_t'(cfg_index))
				mfmt_pkg::CFG_EXPECTED_ID: expected_id_q <= cfg_wdata[mfmt_pkg::ID_W-1:0];
				mfmt_pkg::CFG_GEAR_RATIO:  gear_ratio_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// count difference, wrapped at half a turn, and the divisor 8191 * ratio
	always_comb begin
		d_raw = signed'({1'b0, dec_q.count}) - signed'({1'b0, prev_count_q});
		if (d_raw >= mfmt_pkg::HALF_POS) begin
			d_wrap = d_raw - mfmt_pkg::FULL_S;
		end else if (d_raw <= mfmt_pkg::HALF_NEG) begin
			d_wrap = d_raw + mfmt_pkg::FULL_S;
		end else begin
			d_wrap = d_raw;
		end
		d_neg     = 14'(-d_wrap);
		mag       = d_wrap[13] ? d_neg[mfmt_pkg::MAG_W-1:0] : d_wrap[mfmt_pkg::MAG_W-1:0];
		mag_ext   = {9'd0, mag};
		// 360 = 256 + 64 + 32 + 8
		mag360    = (mag_ext << 8) + (mag_ext << 6) + (mag_ext << 5) + (mag_ext << 3);
		// a zero ratio counts as the smallest nonzero ratio
		ratio_eff = (gear_ratio_q == '0) ? 16'd1 : gear_ratio_q;
		den       = {ratio_eff, 13'd0} - {13'd0, ratio_eff};
	end

	// |d| * 360 * 2^24 plus half the divisor rounds the quotient to nearest
	assign dividend = {1'b0, mag360_q, 24'd0} + {18'd0, den_q[mfmt_pkg::DIVISOR_W-1:1]};

	// apply the sign and add one bit wider; the angle state saturates to the 48-bit range
	always_comb begin
		q_s = neg_q ? -signed'({1'b0, quotient}) : signed'({1'b0, quotient});
		sum = signed'({acc_q[mfmt_pkg::ANGLE_W-1], acc_q}) + 49'(q_s);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mfmt_pkg::ST_IDLE: begin
				if (s_axis_tvalid && dec.id_match) begin
					state_d = awaiting_q ? mfmt_pkg::ST_DONE : mfmt_pkg::ST_PREP;
				end
			end
			mfmt_pkg::ST_PREP:  state_d = mfmt_pkg::ST_LOAD;
			mfmt_pkg::ST_LOAD:  state_d = mfmt_pkg::ST_DIV;
			mfmt_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = mfmt_pkg::ST_ACCUM;
				end
			end
			mfmt_pkg::ST_ACCUM: state_d = mfmt_pkg::ST_DONE;
			mfmt_pkg::ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = mfmt_pkg::ST_IDLE;
				end
			end
			default: state_d = mfmt_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			mfmt_pkg::ST_IDLE: s_axis_tready = 1'b1;
			mfmt_pkg::ST_LOAD: div_start     = 1'b1;
			mfmt_pkg::ST_DONE: out_load      = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfmt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// angle state: capture the start count, or commit the new sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q   <= 1'b1;
			prev_count_q <= '0;
			acc_q        <= '0;
		end else if (in_acc && dec.id_match && awaiting_q) begin
			awaiting_q   <= 1'b0;
			prev_count_q <= dec.count;
			acc_q        <= '0;
		end else if (state_q == mfmt_pkg::ST_ACCUM) begin
			prev_count_q <= dec_q.count;
			if (sum[48] != sum[47]) begin
				acc_q <= sum[48] ? mfmt_pkg::ACC_MIN : mfmt_pkg::ACC_MAX;
			end else begin
				acc_q <= sum[mfmt_pkg::ANGLE_W-1:0];
			end
		end
	end

	// frame and operand holding registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dec_q   <= dec;
			first_q <= awaiting_q;
		end
		if (state_q == mfmt_pkg::ST_PREP) begin
			neg_q    <= d_wrap[13];
			mag360_q <= mag360;
			den_q    <= den;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_angle_q   <= acc_q;
			out_speed_q   <= dec_q.speed;
			out_current_q <= dec_q.current;
			out_temp_q    <= dec_q.temp;
			out_first_q   <= first_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_temp_q, out_current_q, out_speed_q, out_angle_q};
	assign m_axis_tuser  = out_first_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == mfmt_pkg::ST_DIV)
		else $error("divider finished outside the divide phase");

	a_first_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && dec.id_match && awaiting_q) |=> (state_q == mfmt_pkg::ST_DONE && first_q))
		else $error("first frame did not go straight to result");

	a_mismatch_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !dec.id_match) |=> state_q == mfmt_pkg::ST_IDLE)
		else $error("foreign frame was not dropped");

	a_start_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!awaiting_q |=> !awaiting_q)
		else $error("start position captured twice");

	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && first_q) |=> out_angle_q == '0)
		else $error("first frame reported a nonzero angle");

endmodule

### tb/motor_feedback_multiturn_tracker_test.sv
`timescale 1ns / 100ps

module motor_feedback_multiturn_tracker_test;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 7;
	localparam int HOLD_CYCLES    = 500;   // long output hold-off, fills the block
	localparam int SETTLE_CYCLES  = 40;    // covers a full divide pass
	localparam int WATCHDOG_LIMIT = 4000;  // cycles without any word moving
	localparam int REPORT_LIMIT   = 10;

	localparam int ROTOR_COUNTS = 8191;    // one rotor turn
	localparam int HALF_TURN    = 4096;
	localparam longint ANGLE_TOP      = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ANGLE_BOTTOM   = -ANGLE_TOP - 1;
	localparam longint CURRENT_TOP    = 163835;
	localparam longint CURRENT_BOTTOM = -163840;

	// Input word as it sits on s_axis_tdata, top bits first.
	typedef struct packed {
		logic [4:0]                pad;
		logic [7:0]                temp_byte;
		logic [7:0]                current_low;
		logic [7:0]                current_high;
		logic [7:0]                speed_low;
		logic [7:0]                speed_high;
		logic [7:0]                angle_low;
		logic [7:0]                angle_high;
		logic [mfmt_pkg::ID_W-1:0] frame_id;
	} frame_t;

	// Output word: m_axis_tuser on top of m_axis_tdata.
	typedef struct packed {
		logic                                     first_frame;
		logic [4:0]                               pad;
		logic [mfmt_pkg::TEMP_W-1:0]              temperature;
		logic signed [mfmt_pkg::CURRENT_W-1:0]    current_amps;
		logic signed [mfmt_pkg::SPEED_W-1:0]      speed_rpm;
		logic signed [mfmt_pkg::ANGLE_W-1:0]      output_angle;
	} report_t;

	// One row of the directed table; speed and temperature pass straight
	// through, so a typed row only spells out angle, current and the flag.
	typedef struct packed {
		logic [10:0]        frame_id;
		logic [15:0]        angle;
		logic [15:0]        speed;
		logic [15:0]        current;
		logic [7:0]         temp;
		logic               typed;
		logic signed [47:0] angle_out;
		logic signed [18:0] current_out;
		logic               first;
	} vector_t;

	localparam int NUM_DIRECTED = 19;

	// Runs at the reset settings: id 513, ratio 4916.
	localparam vector_t DIRECTED [NUM_DIRECTED] = '{
		// foreign id before anything was captured: dropped
		'{11'd512,  16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 48'sd0, 19'sd0, 1'b0},
		// first frame: capture only, top speed and current
		'{11'd513,  16'h0000, 16'h7FFF, 16'h7FFF, 8'hFF, 1'b1, 48'sd0, 19'sd163835, 1'b1},
		// no motion, bottom speed and current
		'{11'd513,  16'h0000, 16'h8000, 16'h8000, 8'h00, 1'b1, 48'sd0, -19'sd163840, 1'b0},
		// raw angle above range clamps to 8191, which is zero counts away
		'{11'd513,  16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h80, 1'b1, 48'sd0, -19'sd10, 1'b0},
		'{11'd513,  16'h2000, 16'h0001, 16'h3FFF, 8'h7F, 1'b1, 48'sd0, 19'sd163830, 1'b0},
		// back to zero is a full turn, wraps to nothing; current just over the top
		'{11'd513,  16'h0000, 16'h0000, 16'h4000, 8'h01, 1'b1, 48'sd0, 19'sd163835, 1'b0},
		// half-turn edges of the wrap
		'{11'd513,  16'h0FFF, 16'h1234, 16'hC000, 8'h40, 1'b0, 48'sd0, 19'sd0, 1'b0},
		'{11'd513,  16'h0000, 16'hEDCB, 16'hBFFF, 8'h20, 1'b0, 48'sd0, 19'sd0, 1'b0},
		'{11'd513,  16'h1000, 16'h0100, 16'h0001, 8'h10, 1'b0, 48'sd0, 19'sd0, 1'b0},
		'{11'd513,  16'h0000, 16'hFF00, 16'hFFFE, 8'h08, 1'b0, 48'sd0, 19'sd0, 1'b0},
		// foreign ids at both ends of the range
		'{11'd2047, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, 48'sd0, 19'sd0, 1'b0},
		'{11'd0,    16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 48'sd0, 19'sd0, 1'b0},
		// single count, then small steps across the zero seam
		'{11'd513,  16'h0001, 16'h0002, 16'h0003, 8'h04, 1'b0, 48'sd0, 19'sd0, 1'b0},
		'{11'd513,  16'h1FFE, 16'h7FFE, 16'h8001, 8'hFE, 1'b0, 48'sd0, 19'sd0, 1'b0},
		'{11'd513,  16'h0000, 16'h8001, 16'h7FFE, 8'hEF, 1'b0, 48'sd0, 19'sd0, 1'b0},
		'{11'd513,  16'hFF00, 16'h00FF, 16'h00FF, 8'h3C, 1'b0, 48'sd0, 19'sd0, 1'b0},
		'{11'd513,  16'h5A5A, 16'h5AA5, 16'hA55A, 8'h5A, 1'b0, 48'sd0, 19'sd0, 1'b0},
		'{11'd513,  16'h0AAA, 16'hA55A, 16'h5AA5, 8'hA5, 1'b0, 48'sd0, 19'sd0, 1'b0},
		'{11'd513,  16'h1555, 16'h00FF, 16'hFF00, 8'h02, 1'b0, 48'sd0, 19'sd0, 1'b0}
	};

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	logic [mfmt_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [mfmt_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
	logic [0:0]                          m_axis_tuser;
	logic                                cfg_we = 1'b0;
	mfmt_pkg::cfg_index_t                cfg_index = mfmt_pkg::CFG_EXPECTED_ID;
	logic [mfmt_pkg::CFG_W-1:0]          cfg_wdata = '0;

	// Typed expectation that travels alongside the input word.
	logic                                s_typed = 1'b0;
	report_t                             s_typed_want = '0;

	// Tracker copy: register settings and angle state, at reset values.
	logic [mfmt_pkg::ID_W-1:0]           want_id = 11'd513;
	logic [mfmt_pkg::RATIO_W-1:0]        gear_q8 = 16'd4916;
	logic                                capture_pending = 1'b1;
	longint                              last_count = 0;
	longint                              shaft_angle = 0;

	report_t                             pending_feedback [$];

	int unsigned                         send_idle_pct = 0;
	int unsigned                         recv_stall_pct = 0;
	logic                                hold_req = 1'b0;
	int                                  hold_left = 0;
	int                                  rotor_pos = 0;
	int                                  frames_taken = 0;
	int                                  words_checked = 0;
	int                                  bad_words = 0;

	motor_feedback_multiturn_tracker u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Advance the tracker by one frame; return 1 when the frame yields a word.
	function automatic logic track_frame(input frame_t f, output report_t r);
		longint count, delta, sum, amps;
		longint unsigned ratio, den, mag, quot;
		r = '0;
		if (f.frame_id != want_id)
			return 1'b0;
		count = longint'({f.angle_high, f.angle_low});
		if (count > ROTOR_COUNTS)
			count = ROTOR_COUNTS;
		if (capture_pending) begin
			// first matching frame only pins the start position
			capture_pending = 1'b0;
			shaft_angle = 0;
			r.first_frame = 1'b1;
		end else begin
			delta = count - last_count;
			if (delta >= HALF_TURN)
				delta -= ROTOR_COUNTS;
			else if (delta <= -HALF_TURN)
				delta += ROTOR_COUNTS;
			// zero ratio acts as 1/256
			ratio = (gear_q8 == '0) ? 64'd1 : 64'(gear_q8);
			den = 64'(ROTOR_COUNTS) * ratio;
			mag = (delta < 0) ? 64'(-delta) : 64'(delta);
			// degrees * 2^16, ratio in Q8.8: scale by 360 * 2^24, round half away
			quot = (mag * 360 * 256 * 65536 + den / 2) / den;
			sum = shaft_angle + ((delta < 0) ? -longint'(quot) : longint'(quot));
			if (sum > ANGLE_TOP)
				sum = ANGLE_TOP;
			if (sum < ANGLE_BOTTOM)
				sum = ANGLE_BOTTOM;
			shaft_angle = sum;
		end
		last_count = count;
		amps = longint'($signed({f.current_high, f.current_low})) * 10;
		if (amps > CURRENT_TOP)
			amps = CURRENT_TOP;
		if (amps < CURRENT_BOTTOM)
			amps = CURRENT_BOTTOM;
		r.output_angle = shaft_angle[47:0];
		r.speed_rpm = {f.speed_high, f.speed_low};
		r.current_amps = amps[18:0];
		r.temperature = f.temp_byte;
		return 1'b1;
	endfunction

	// Build one random frame. spin != 0 turns the rotor close to half a turn
	// per frame in that direction, to carry the accumulator far from zero.
	function automatic frame_t make_frame(input int spin);
		frame_t f;
		int step, raw, cur;
		int unsigned pick;
		f = '0;
		{f.speed_high, f.speed_low} = 16'($urandom);
		if ($urandom_range(3) == 0)
			cur = int'($urandom_range(65535));
		else
			cur = int'($urandom_range(33000)) - 16500;
		{f.current_high, f.current_low} = 16'(cur);
		f.temp_byte = 8'($urandom);
		// a tenth are foreign frames: random id and angle, rotor untouched
		if ($urandom_range(99) < 10) begin
			f.frame_id = 11'($urandom);
			if (f.frame_id == want_id)
				f.frame_id = ~f.frame_id;
			{f.angle_high, f.angle_low} = 16'($urandom);
			return f;
		end
		f.frame_id = want_id;
		pick = $urandom_range(99);
		if (spin == 0 && pick >= 93) begin
			// raw angle anywhere, over-range values included
			raw = int'($urandom_range(65535));
			rotor_pos = (raw > ROTOR_COUNTS) ? ROTOR_COUNTS : raw;
		end else begin
			if (spin != 0)
				step = spin * int'($urandom_range(4095, 3900));
			else if (pick < 65)
				step = int'($urandom_range(400)) - 200;
			else if (pick < 85)
				step = int'($urandom_range(8190)) - 4095;
			else
				step = ($urandom_range(1) ? 1 : -1) * (4095 + int'($urandom_range(1)));
			rotor_pos = ((rotor_pos + step) % 8192 + 8192) % 8192;
			raw = rotor_pos;
		end
		{f.angle_high, f.angle_low} = 16'(raw);
		return f;
	endfunction

	// Offer one word, idling first as the sender rate says; return at the
	// falling edge after it was taken, with tvalid still high.
	task automatic send_frame(input frame_t f, input logic typed, input report_t typed_want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= f;
		s_typed <= typed;
		s_typed_want <= typed_want;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Drop tvalid, wait for every outstanding word, then hold for extra cycles.
	task automatic settle(input int extra);
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending_feedback.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	// Write both registers on back-to-back edges; only called while idle.
	task automatic program_tracker(input logic [10:0] id, input logic [15:0] ratio);
		cfg_we <= 1'b1;
		cfg_index <= mfmt_pkg::CFG_EXPECTED_ID;
		cfg_wdata <= 16'(id);
		want_id = id;
		@(negedge clk);
		cfg_index <= mfmt_pkg::CFG_GEAR_RATIO;
		cfg_wdata <= ratio;
		gear_q8 = ratio;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random phase under one register setting and one idling mix.
	// Halfway through, the sender waits for all results; spin reverses there,
	// and a squeeze phase starts the long output hold-off at that point.
	task automatic run_phase(input logic [10:0] id, input logic [15:0] ratio,
			input int unsigned idle_pct, input int unsigned stall_pct,
			input int frames, input int spin, input logic squeeze);
		int matched;
		logic paused;
		frame_t f;
		report_t unused;
		settle(SETTLE_CYCLES);
		program_tracker(id, ratio);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		matched = 0;
		paused = 1'b0;
		unused = '0;
		while (matched < frames) begin
			if (!paused && matched == frames / 2) begin
				paused = 1'b1;
				settle(0);
				if (squeeze)
					hold_req = 1'b1;
			end
			f = make_frame((matched < frames / 2) ? spin : -spin);
			if (f.frame_id == want_id)
				matched++;
			send_frame(f, 1'b0, unused);
		end
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested.
	always @(negedge clk) begin : receiver
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Sample both handshakes at the rising edge: predict on every taken input
	// word, compare every taken output word with the oldest expectation.
	always @(posedge clk) begin : monitor
		report_t predicted, got, want;
		if (s_axis_tvalid && s_axis_tready) begin
			frames_taken++;
			if (track_frame(frame_t'(s_axis_tdata), predicted))
				pending_feedback.push_back(s_typed ? s_typed_want : predicted);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = report_t'({m_axis_tuser, m_axis_tdata});
			words_checked++;
			if (pending_feedback.size() == 0) begin
				bad_words++;
				if (bad_words <= REPORT_LIMIT)
					$display("%0t: unexpected word: angle %0d speed %0d current %0d",
						$realtime, got.output_angle, got.speed_rpm, got.current_amps);
			end else begin
				want = pending_feedback.pop_front();
				if (got.output_angle !== want.output_angle ||
						got.speed_rpm !== want.speed_rpm ||
						got.current_amps !== want.current_amps ||
						got.temperature !== want.temperature ||
						got.first_frame !== want.first_frame) begin
					bad_words++;
					if (bad_words <= REPORT_LIMIT) begin
						$display("%0t: word %0d mismatch (expected/actual): angle %0d/%0d",
							$realtime, words_checked, want.output_angle, got.output_angle);
						$display("  speed %0d/%0d current %0d/%0d temp %0d/%0d first %0b/%0b",
							want.speed_rpm, got.speed_rpm,
							want.current_amps, got.current_amps,
							want.temperature, got.temperature,
							want.first_frame, got.first_frame);
					end
				end
			end
		end
	end

	// Watchdog: end the run when no word moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no word moved for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, pending_feedback.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : stimulus
		int i;
		frame_t f;
		report_t want;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table at reset settings, no idling.
		for (i = 0; i < NUM_DIRECTED; i++) begin
			f = '0;
			f.frame_id = DIRECTED[i].frame_id;
			{f.angle_high, f.angle_low} = DIRECTED[i].angle;
			{f.speed_high, f.speed_low} = DIRECTED[i].speed;
			{f.current_high, f.current_low} = DIRECTED[i].current;
			f.temp_byte = DIRECTED[i].temp;
			want = '0;
			want.output_angle = DIRECTED[i].angle_out;
			want.speed_rpm = DIRECTED[i].speed;
			want.current_amps = DIRECTED[i].current_out;
			want.temperature = DIRECTED[i].temp;
			want.first_frame = DIRECTED[i].first;
			send_frame(f, DIRECTED[i].typed, want);
		end

		// Random phases: id and ratio extremes, every idling mix, then spins
		// at the smallest ratios that carry the accumulator far out and back.
		run_phase(11'd0, 16'd65535, 0, 0, 300, 0, 1'b0);
		run_phase(11'd2047, 16'd256, 45, 0, 250, 0, 1'b0);
		run_phase(11'($urandom), 16'($urandom_range(65535, 256)), 0, 45, 250, 0, 1'b1);
		run_phase(11'd513, 16'd4916, 28, 28, 250, 0, 1'b0);
		run_phase(11'($urandom), 16'd0, 0, 0, 240, 1, 1'b0);
		run_phase(11'($urandom), 16'd1, 28, 28, 240, -1, 1'b1);
		run_phase(11'($urandom), 16'd255, 45, 0, 160, 0, 1'b0);

		settle(SETTLE_CYCLES);
		$display("Run took %0d frames and checked %0d decoded words (%0d mismatched),",
			frames_taken, words_checked, bad_words);
		$display("across id and gear ratio extremes, long one-way spins and output hold-offs.");
		if (bad_words == 0 && pending_feedback.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### motor_feedback_multiturn_tracker.f
design/mfmt_pkg.sv
design/mfmt_decode.sv
design/mfmt_div.sv
design/motor_feedback_multiturn_tracker.sv
tb/motor_feedback_multiturn_tracker_test.sv
